// ===== rtl/core/rcli_pkg.sv =====
`default_nettype none

package rcli_pkg;

	// Width of one color channel and of a packed 24-bit RGB color
	localparam int CH_W    = 8;
	localparam int COLOR_W = 3 * CH_W;

	// Default width of the step count and of total_steps
	localparam int STEP_WIDTH_DEF = 16;

	// One quotient bit per divider stage, plus the multiply stage
	localparam int DIV_STEPS   = CH_W;
	localparam int LANE_STAGES = 1 + DIV_STEPS;

	localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// Register map: byte address bits [ADDR_W-1:2] select the register
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_TOTAL_STEPS = 1'b0;
	localparam int TOTAL_STEPS_RST = 1;

endpackage

`default_nettype wire

// ===== rtl/core/rcli_lane.sv =====
`default_nettype none

// One channel: |end - start| * step, then an 8-stage restoring divide by total,
// then the quotient is added to or subtracted from start (end itself once step >= total).
module rcli_lane #(
	parameter int STEP_WIDTH = rcli_pkg::STEP_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic [rcli_pkg::LANE_STAGES-1:0]  adv,
	input  wire logic [rcli_pkg::CH_W-1:0]         start_ch,
	input  wire logic [rcli_pkg::CH_W-1:0]         end_ch,
	input  wire logic [STEP_WIDTH-1:0]             step,
	input  wire logic [STEP_WIDTH-1:0]             total,
	output logic      [rcli_pkg::CH_W-1:0]         ch
);

	localparam int CW     = rcli_pkg::CH_W;
	localparam int NDIV   = rcli_pkg::DIV_STEPS;
	localparam int PROD_W = CW + STEP_WIDTH;

	// multiply stage
	logic            dir;
	logic [CW-1:0]   span;
	logic [PROD_W-1:0] prod;

	logic [STEP_WIDTH-1:0] rem_s2;
	logic [CW-1:0]         lo_s2, a_s2, b_s2;
	logic                  dir_s2, pass_s2;

	assign dir  = end_ch > start_ch;
	assign span = dir ? (end_ch - start_ch) : (start_ch - end_ch);
	assign prod = PROD_W'(span) * PROD_W'(step);

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s2  <= prod[PROD_W-1:CW];
			lo_s2   <= prod[CW-1:0];
			a_s2    <= start_ch;
			b_s2    <= end_ch;
			dir_s2  <= dir;
			pass_s2 <= step >= total;
		end
	end

	// divider stages, s3 onward: one entry per quotient bit, MSB first
	logic [STEP_WIDTH-1:0] rem_s3 [NDIV];
	logic [CW-1:0]         lo_s3  [NDIV];
	logic [CW-1:0]         q_s3   [NDIV];
	logic [CW-1:0]         a_s3   [NDIV];
	logic [CW-1:0]         b_s3   [NDIV];
	logic                  dir_s3 [NDIV];
	logic                  pass_s3[NDIV];

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		logic [STEP_WIDTH-1:0] rem_in;
		logic [CW-1:0]         lo_in, q_in, a_in, b_in;
		logic                  dir_in, pass_in;
		logic [STEP_WIDTH:0]   trial, trial_sub;
		logic                  ge;

		if (i == 0) begin : g_first
			assign rem_in  = rem_s2;
			assign lo_in   = lo_s2;
			assign q_in    = '0;
			assign a_in    = a_s2;
			assign b_in    = b_s2;
			assign dir_in  = dir_s2;
			assign pass_in = pass_s2;
		end else begin : g_next
			assign rem_in  = rem_s3[i-1];
			assign lo_in   = lo_s3[i-1];
			assign q_in    = q_s3[i-1];
			assign a_in    = a_s3[i-1];
			assign b_in    = b_s3[i-1];
			assign dir_in  = dir_s3[i-1];
			assign pass_in = pass_s3[i-1];
		end

		assign trial     = {rem_in, lo_in[CW-1]};
		assign ge        = trial >= {1'b0, total};
		assign trial_sub = trial - {1'b0, total};

		always_ff @(posedge clk) begin
			if (adv[i+1]) begin
				rem_s3[i]  <= ge ? trial_sub[STEP_WIDTH-1:0] : trial[STEP_WIDTH-1:0];
				lo_s3[i]   <= {lo_in[CW-2:0], 1'b0};
				q_s3[i]    <= {q_in[CW-2:0], ge};
				a_s3[i]    <= a_in;
				b_s3[i]    <= b_in;
				dir_s3[i]  <= dir_in;
				pass_s3[i] <= pass_in;
			end
		end
	end

	// quotient <= span, so the add or subtract never wraps
	always_comb begin
		if (pass_s3[NDIV-1]) begin
			ch = b_s3[NDIV-1];
		end else if (dir_s3[NDIV-1]) begin
			ch = a_s3[NDIV-1] + q_s3[NDIV-1];
		end else begin
			ch = a_s3[NDIV-1] - q_s3[NDIV-1];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_color_linear_interp.sv =====
// Pipeline: from an input transfer to the result on m_tdata (input register, multiply
//   stage, 8 divider stages, output register; the input register loads at the
//   transfer edge); a stalled m_tready holds results back in the registers.
// Throughput: one item per cycle unless m_tready stalls a full pipeline; each lane's 8-stage
//   pipelined restoring divider (one quotient bit per stage) accepts a new dividend as it advances.
// Reset (arst_n low, asynchronous): all stage valid bits and m_tvalid clear,
//   total_steps returns to 1.
`default_nettype none

module rgb_color_linear_interp #(
	parameter int STEP_WIDTH = rcli_pkg::STEP_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, low bit up: start_color[23:0], end_color[47:24],
	//   step[48+STEP_WIDTH-1:48], zero pad to whole bytes
	input  wire logic [((2*rcli_pkg::COLOR_W+STEP_WIDTH+7)/8)*8-1:0] s_tdata,

	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata, low bit up: blended_color[31:0] (blue, green, red, alpha)
	output logic [31:0]      m_tdata,

	// configuration port
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [rcli_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready
);

	localparam int CW  = rcli_pkg::CH_W;
	localparam int CLW = rcli_pkg::COLOR_W;
	localparam int LAT = rcli_pkg::LANE_STAGES;

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [STEP_WIDTH-1:0] total_steps_q;
	logic                  cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = paddr[rcli_pkg::ADDR_W-1:2] == rcli_pkg::REG_TOTAL_STEPS;
	assign prdata  = cfg_sel ? 32'(total_steps_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_steps_q <= STEP_WIDTH'(rcli_pkg::TOTAL_STEPS_RST);
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			total_steps_q <= pwdata[STEP_WIDTH-1:0];
		end
	end

	// ---------------------------------------------------------------
	// Flow control. Each stage advances when it is empty or the next
	// one advances, so bubbles collapse and a stalled output only
	// blocks input once every stage is full.
	//   v_q[0]      : input register (s1)
	//   v_q[1..LAT] : lane stages (s2..s10)
	// ---------------------------------------------------------------
	logic [LAT:0] v_q;
	logic [LAT:0] adv;
	logic         out_adv;

	assign out_adv = !m_tvalid || m_tready;

	always_comb begin
		adv[LAT] = !v_q[LAT] || out_adv;
		for (int k = LAT - 1; k >= 0; k--) begin
			adv[k] = !v_q[k] || adv[k+1];
		end
	end

	assign s_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q      <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= s_tvalid;
			end
			for (int k = 1; k <= LAT; k++) begin
				if (adv[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
			if (out_adv) begin
				m_tvalid <= v_q[LAT];
			end
		end
	end

	// ---------------------------------------------------------------
	// Input register (s1)
	// ---------------------------------------------------------------
	logic [CLW-1:0]        start_s1, end_s1;
	logic [STEP_WIDTH-1:0] step_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			start_s1 <= s_tdata[CLW-1:0];
			end_s1   <= s_tdata[2*CLW-1:CLW];
			step_s1  <= s_tdata[2*CLW+STEP_WIDTH-1:2*CLW];
		end
	end

	// ---------------------------------------------------------------
	// Channel lanes: blue, green, red side by side
	// ---------------------------------------------------------------
	logic [CW-1:0] lane_ch [3];

	for (genvar c = 0; c < 3; c++) begin : g_lane
		rcli_lane #(
			.STEP_WIDTH (STEP_WIDTH)
		) u_lane (
			.clk      (clk),
			.adv      (adv[LAT:1]),
			.start_ch (start_s1[c*CW +: CW]),
			.end_ch   (end_s1[c*CW +: CW]),
			.step     (step_s1),
			.total    (total_steps_q),
			.ch       (lane_ch[c])
		);
	end

	// ---------------------------------------------------------------
	// Merge: alpha on top, lanes packed into ARGB, output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (out_adv && v_q[LAT]) begin
			m_tdata <= {rcli_pkg::ALPHA_OPAQUE, lane_ch[2], lane_ch[1], lane_ch[0]};
		end
	end

`ifndef ASSERT_OFF
	// empty output register means every stage can move, so input is open
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output register empty");

	// input only stalls once the whole pipeline is full
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (&v_q) && m_tvalid)
		else $error("input stalled with a bubble in the pipeline");

	// a finished lane result moving out must appear at the output
	a_last_stage_drains: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[LAT] && adv[LAT] |=> m_tvalid)
		else $error("lane result lost at merge stage");

	// merge always sets opaque alpha
	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:24] == rcli_pkg::ALPHA_OPAQUE)
		else $error("alpha byte not opaque");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_rgb_color_linear_interp.sv =====
`default_nettype none

module tb_rgb_color_linear_interp;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEP_W    = rcli_pkg::STEP_WIDTH_DEF;
	localparam int S_DATA_W  = ((2 * rcli_pkg::COLOR_W + STEP_W + 7) / 8) * 8;
	// input reg + multiply + 8 divider stages + output reg
	localparam int PIPE_LAT  = 11;
	localparam int CYCLE_CAP = 400000;
	localparam int ITEMS_PER_PHASE = 148;
	localparam logic [rcli_pkg::ADDR_W-1:0] TOTAL_STEPS_ADDR =
		{rcli_pkg::REG_TOTAL_STEPS, 2'b00};

	// Expected-color store plus its own copy of total_steps.
	class blend_scoreboard;
		logic [STEP_W-1:0] total_steps;
		logic [31:0]       color_q[$];
		int                errors;

		function new();
			total_steps = STEP_W'(rcli_pkg::TOTAL_STEPS_RST);
			errors = 0;
		endfunction

		function void set_total(input logic [STEP_W-1:0] n);
			total_steps = n;
		endfunction

		function int pending();
			return color_q.size();
		endfunction

		function logic [rcli_pkg::CH_W-1:0] lerp_channel(input logic [rcli_pkg::CH_W-1:0] a,
				input logic [rcli_pkg::CH_W-1:0] b, input logic [STEP_W-1:0] t);
			logic [31:0] span;
			logic [31:0] part;
			span = 32'((b > a) ? b - a : a - b);
			part = (span * t) / total_steps;
			return (b > a) ? a + part[rcli_pkg::CH_W-1:0] : a - part[rcli_pkg::CH_W-1:0];
		endfunction

		function logic [31:0] blend(input logic [rcli_pkg::COLOR_W-1:0] c0,
				input logic [rcli_pkg::COLOR_W-1:0] c1, input logic [STEP_W-1:0] t);
			// zero total falls in here too, so no divide by zero
			if (t >= total_steps)
				return {rcli_pkg::ALPHA_OPAQUE, c1};
			return {rcli_pkg::ALPHA_OPAQUE,
				lerp_channel(c0[23:16], c1[23:16], t),
				lerp_channel(c0[15:8], c1[15:8], t),
				lerp_channel(c0[7:0], c1[7:0], t)};
		endfunction

		task note_input(input logic [S_DATA_W-1:0] d);
			color_q.push_back(blend(d[23:0], d[47:24], d[48 +: STEP_W]));
		endtask

		task report(input string msg);
			errors++;
			$display("mismatch %0d: %s", errors, msg);
		endtask

		task check_result(input logic [31:0] got);
			logic [31:0] want;
			if (color_q.size() == 0) begin
				report($sformatf("result %h with nothing expected", got));
				return;
			end
			want = color_q.pop_front();
			if (got !== want)
				report($sformatf("blended_color got %h want %h", got, want));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// s_tdata, low bit up: start_color[23:0], end_color[47:24], step[63:48]
	logic [S_DATA_W-1:0] s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	// m_tdata, low bit up: blended_color[31:0]
	logic [31:0]         m_tdata;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [rcli_pkg::ADDR_W-1:0] paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	blend_scoreboard sb = new();

	// percent chances per cycle: sender holding back, receiver stalling
	int send_idle  = 0;
	int recv_stall = 0;
	// long receiver hold-off, counted down by the receiver process
	int hold_left  = 0;

	rgb_color_linear_interp u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Both monitors sample pre-edge values, so they see exactly what the DUT saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// Receiver: random stalls, or a solid hold-off while hold_left runs down.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	// Watchdog: generous bound over the slowest legal run.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$display("watchdog expired with %0d colors outstanding", sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

	// One input transfer; random idle cycles ahead of it per send_idle.
	task automatic send_blend(input logic [rcli_pkg::COLOR_W-1:0] c0,
			input logic [rcli_pkg::COLOR_W-1:0] c1, input logic [STEP_W-1:0] t);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {t, c1, c0};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid and wait for the pipeline to empty out. The first edge lets
	// the monitor note the last transfer before the count is read.
	task automatic drain_pipe();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	// APB write: setup cycle then access cycle; register updates at the access edge.
	task automatic write_total(input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TOTAL_STEPS_ADDR;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_total(val[STEP_W-1:0]);
	endtask

	// Random color pair, sometimes with equal channels.
	task automatic random_blend(input logic [STEP_W-1:0] n);
		logic [rcli_pkg::COLOR_W-1:0] c0;
		logic [rcli_pkg::COLOR_W-1:0] c1;
		logic [STEP_W-1:0]  t;
		int                 pick;
		int                 ch;
		c0 = rcli_pkg::COLOR_W'($urandom);
		c1 = rcli_pkg::COLOR_W'($urandom);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			c1 = c0;
		end else if (pick == 1) begin
			ch = $urandom_range(0, 2);
			c1[ch*rcli_pkg::CH_W +: rcli_pkg::CH_W] = c0[ch*rcli_pkg::CH_W +: rcli_pkg::CH_W];
		end
		// mostly inside the ramp; the rest lands on the end or anywhere
		pick = $urandom_range(0, 9);
		if (n == 0 || pick >= 8)
			t = STEP_W'($urandom_range(0, (1 << STEP_W) - 1));
		else if (pick == 7)
			t = n;
		else
			t = STEP_W'($urandom_range(0, n - 1));
		send_blend(c0, c1, t);
	endtask

	initial begin
		logic [31:0] total_list[8];
		int          phase;
		int          k;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: ten-step ramp, both directions, ends and past the end
		write_total(10);
		send_blend(24'h000000, 24'h000000, 16'd0);
		send_blend(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		send_blend(24'h000000, 24'hFFFFFF, 16'd0);
		send_blend(24'h000000, 24'hFFFFFF, 16'd1);
		send_blend(24'h000000, 24'hFFFFFF, 16'd5);
		send_blend(24'h000000, 24'hFFFFFF, 16'd9);
		send_blend(24'hFFFFFF, 24'h000000, 16'd9);
		send_blend(24'hFFFFFF, 24'h000000, 16'd10);
		send_blend(24'hFFFFFF, 24'h000000, 16'd11);
		send_blend(24'h123456, 24'hFEDCBA, 16'hFFFF);
		// mixed directions with green unchanged
		send_blend(24'h80FF00, 24'h00FF80, 16'd3);
		send_blend(24'hAABBCC, 24'hAABBCC, 16'd4);
		send_blend(24'h00FF00, 24'hFF00FF, 16'd7);
		send_blend(24'hFFFFFF, 24'h000000, 16'd0);
		drain_pipe();

		// zero total: always the end color
		write_total(0);
		send_blend(24'h000000, 24'hFFFFFF, 16'd0);
		send_blend(24'hAAAAAA, 24'h555555, 16'd0);
		send_blend(24'h123456, 24'h654321, 16'hFFFF);
		drain_pipe();

		// widest total: quotients near the top of the range
		write_total(32'h0000FFFF);
		send_blend(24'h000000, 24'hFFFFFF, 16'hFFFE);
		send_blend(24'hFFFFFF, 24'h000000, 16'hFFFE);
		send_blend(24'h000000, 24'hFFFFFF, 16'h8000);
		send_blend(24'h01FE7F, 24'hFE0180, 16'h7FFF);
		send_blend(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF);
		drain_pipe();

		// Random phases, each with its own total and idle pattern
		total_list = '{32'd1, 32'd0, 32'h0000FFFF, 32'd7, 32'd256, 32'd3, 32'd255,
			32'($urandom_range(1, 65535))};
		for (phase = 0; phase < 8; phase++) begin
			write_total(total_list[phase]);
			case (phase % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 69; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 69; end
				default: begin send_idle = 31; recv_stall = 31; end
			endcase
			// back-pressure: receiver blocked while the sender keeps pushing
			if (phase == 0)
				hold_left = 300;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// sender pause until every result is back
				if (phase == 1 && k == ITEMS_PER_PHASE / 2)
					drain_pipe();
				random_blend(sb.total_steps);
			end
			drain_pipe();
		end

		send_idle  = 0;
		recv_stall = 0;
		repeat (2 * PIPE_LAT) @(posedge clk);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/rcli_pkg.sv
rtl/core/rcli_lane.sv
rtl/core/rgb_color_linear_interp.sv
sim/tb_rgb_color_linear_interp.sv
